/* hdl/mlbt_pkg.sv */
// Shared types and constants for the multibyte lead byte tracker.
package mlbt_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CHAR_W      = 16;
  localparam int STATE_W     = 3;
  localparam int ENC_W       = 4;
  localparam int BYTE_W      = 8;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // Register index of the encoding selector, taken from the word address.
  localparam logic REG_ENCODING = 1'b0;

  typedef logic [STATE_W-1:0] state_t;

  typedef enum logic [ENC_W-1:0] {
    ENC_SINGLE   = 4'd0,
    ENC_UTF8     = 4'd1,
    ENC_SJIS2004 = 4'd2,
    ENC_SJIS     = 4'd3,
    ENC_BIG5     = 4'd4,
    ENC_GBK      = 4'd5,
    ENC_UHC      = 4'd6,
    ENC_EUC_JP   = 4'd7,
    ENC_EUC_CN   = 4'd8,
    ENC_EUC_TW   = 4'd9,
    ENC_GB18030  = 4'd10
  } enc_t;

  localparam logic [BYTE_W-1:0] B_FC = 8'hfc;
  localparam logic [BYTE_W-1:0] B_F8 = 8'hf8;
  localparam logic [BYTE_W-1:0] B_F0 = 8'hf0;
  localparam logic [BYTE_W-1:0] B_E0 = 8'he0;
  localparam logic [BYTE_W-1:0] B_C0 = 8'hc0;
  localparam logic [BYTE_W-1:0] B_8F = 8'h8f;
  localparam logic [BYTE_W-1:0] B_8E = 8'h8e;
  localparam logic [BYTE_W-1:0] B_A0 = 8'ha0;
  localparam logic [BYTE_W-1:0] B_30 = 8'h30;
  localparam logic [BYTE_W-1:0] B_39 = 8'h39;
  localparam logic [BYTE_W-1:0] B_9F = 8'h9f;
  localparam logic [BYTE_W-1:0] B_81 = 8'h81;
  localparam logic [BYTE_W-1:0] B_7F = 8'h7f;
  localparam logic [BYTE_W-1:0] B_80 = 8'h80;

endpackage

/* hdl/multibyte_lead_byte_tracker.sv */
// Top level of the multibyte lead byte tracker: state update, count and APB register.
// The result of an accepted byte is registered and offered on result_valid.
// One byte per cycle unless results back up; the state and count update is one short
// combinational step from the held state to the result register.
// Reset (rst, synchronous, active high) clears the tracking state, the character
// count, the result valid flag and selects single-byte encoding.
module multibyte_lead_byte_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mlbt_pkg::PADDR_W-1:0] paddr,
  input  logic [mlbt_pkg::PDATA_W-1:0] pwdata,
  output logic [mlbt_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         text_valid,
  output logic                         text_ready,
  input  logic [mlbt_pkg::BYTE_W-1:0]  text_byte,
  input  logic                         string_start,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic [mlbt_pkg::STATE_W-1:0] lead_state,
  output logic                         at_boundary,
  output logic                         counts_as_char,
  output logic [mlbt_pkg::CHAR_W-1:0]  char_count
);
  import mlbt_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Configuration register. The encoding code is kept as written, so that
  // unused codes fall through to the single-byte rule.
  logic [ENC_W-1:0]       encoding_kind;

  // Tracking state carried from one beat to the next.
  logic [STATE_W-1:0]     track_state;
  logic [COUNT_WIDTH-1:0] char_total;

  logic                   text_beat;
  logic                   cfg_write;
  logic [STATE_W-1:0]     base_state;
  logic [COUNT_WIDTH-1:0] base_total;
  logic [STATE_W-1:0]     track_state_next;
  logic [COUNT_WIDTH-1:0] char_total_next;
  logic                   counted;
  logic [STATE_W-1:0]     s;
  logic [BYTE_W-1:0]      c;
  logic                   s_lt2;
  logic                   c_hi;
  logic                   c_gt_a0;
  logic                   c_digit;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ENCODING);
  assign prdata    = (paddr[2] == REG_ENCODING) ? PDATA_W'(encoding_kind) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      encoding_kind <= ENC_SINGLE;
    end else if (cfg_write) begin
      encoding_kind <= pwdata[ENC_W-1:0];
    end
  end

  // The output register parts the two sides: a new byte is taken whenever
  // the result slot is empty or is being emptied in this cycle.
  assign text_ready = !result_valid || result_ready;
  assign text_beat  = text_valid && text_ready;

  // A string start clears the state and the count before the byte is used.
  assign base_state = string_start ? '0 : track_state;
  assign base_total = string_start ? '0 : char_total;

  // A zero byte forces the state to zero before the encoding rule runs.
  assign c       = text_byte;
  assign s       = (c == '0) ? '0 : base_state;
  assign s_lt2   = (s < STATE_W'(2));
  assign c_hi    = (c > B_7F);
  assign c_gt_a0 = (c > B_A0);
  assign c_digit = (c >= B_30) && (c <= B_39);

  always_comb begin
    track_state_next = '0;
    case (encoding_kind)
      ENC_UTF8: begin
        if (s_lt2 && c_hi) begin
          // A stray continuation byte leaves the state as it was.
          if (c >= B_FC)      track_state_next = STATE_W'(6);
          else if (c >= B_F8) track_state_next = STATE_W'(5);
          else if (c >= B_F0) track_state_next = STATE_W'(4);
          else if (c >= B_E0) track_state_next = STATE_W'(3);
          else if (c >= B_C0) track_state_next = STATE_W'(2);
          else                track_state_next = s;
        end else if (!s_lt2 && c_hi) begin
          track_state_next = s - STATE_W'(1);
        end else begin
          track_state_next = '0;
        end
      end
      ENC_SJIS2004: begin
        if (s_lt2 && (((c >= B_81) && (c <= B_9F)) || ((c >= B_E0) && (c <= B_FC))))
          track_state_next = STATE_W'(2);
        else if (s == STATE_W'(2))
          track_state_next = STATE_W'(1);
        else
          track_state_next = '0;
      end
      ENC_SJIS: begin
        if (s_lt2 && (c > B_80) && !((c > B_9F) && (c < B_E0)))
          track_state_next = STATE_W'(2);
        else if (s == STATE_W'(2))
          track_state_next = STATE_W'(1);
        else
          track_state_next = '0;
      end
      ENC_BIG5, ENC_EUC_CN: begin
        if (s_lt2 && c_gt_a0)       track_state_next = STATE_W'(2);
        else if (s == STATE_W'(2))  track_state_next = STATE_W'(1);
        else                        track_state_next = '0;
      end
      ENC_GBK, ENC_UHC: begin
        if (s_lt2 && c_hi)          track_state_next = STATE_W'(2);
        else if (s == STATE_W'(2))  track_state_next = STATE_W'(1);
        else                        track_state_next = '0;
      end
      ENC_EUC_JP: begin
        if ((s < STATE_W'(3)) && (c == B_8F))
          track_state_next = STATE_W'(3);
        else if ((s != STATE_W'(2)) && ((c == B_8E) || c_gt_a0))
          track_state_next = STATE_W'(2);
        else if (s == STATE_W'(2))
          track_state_next = STATE_W'(1);
        else
          track_state_next = '0;
      end
      ENC_EUC_TW: begin
        if ((s < STATE_W'(4)) && (c == B_8E))
          track_state_next = STATE_W'(4);
        else if ((s == STATE_W'(4)) && c_gt_a0)
          track_state_next = STATE_W'(3);
        else if (((s == STATE_W'(3)) || s_lt2) && c_gt_a0)
          track_state_next = STATE_W'(2);
        else if (s == STATE_W'(2))
          track_state_next = STATE_W'(1);
        else
          track_state_next = '0;
      end
      ENC_GB18030: begin
        // A four-byte sequence is recognised by a digit in the second byte.
        if (s_lt2 && (c > B_80))
          track_state_next = STATE_W'(2);
        else if (s == STATE_W'(2))
          track_state_next = c_digit ? STATE_W'(3) : STATE_W'(1);
        else if (s == STATE_W'(3))
          track_state_next = c_digit ? STATE_W'(1) : STATE_W'(3);
        else
          track_state_next = '0;
      end
      default: begin
        // Single-byte and unused codes: every byte is a whole character.
        track_state_next = '0;
      end
    endcase
  end

  // A byte is counted when it ends a character or stands alone; the total
  // saturates rather than wrapping.
  assign counted         = (track_state_next < STATE_W'(2));
  assign char_total_next = (counted && (base_total != COUNT_MAX)) ?
                           base_total + COUNT_WIDTH'(1) : base_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_state  <= '0;
      char_total   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (text_beat) begin
        track_state  <= track_state_next;
        char_total   <= char_total_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted beat.
  always_ff @(posedge clk) begin
    if (text_beat) begin
      lead_state     <= track_state_next;
      at_boundary    <= (track_state_next == '0);
      counts_as_char <= counted;
      char_count     <= CHAR_W'(char_total_next);
    end
  end

endmodule

/* hdl/mlbt_checker.sv */
// Port-level checker for the multibyte lead byte tracker, with its bind statement.
module mlbt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         text_valid,
  input logic                         text_ready,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic [mlbt_pkg::STATE_W-1:0] lead_state,
  input logic                         at_boundary,
  input logic                         counts_as_char,
  input logic [mlbt_pkg::CHAR_W-1:0]  char_count
);
  import mlbt_pkg::*;

  // The boundary flag must agree with the state it is shown with.
  a_boundary_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (at_boundary == (lead_state == '0)))
    else $error("at_boundary disagrees with lead_state");

  // A byte counts exactly when the state it leaves is below two.
  a_count_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (counts_as_char == (lead_state < STATE_W'(2))))
    else $error("counts_as_char disagrees with lead_state");

  // Every accepted input beat is followed by a result beat on offer.
  a_input_to_result: assert property (@(posedge clk) disable iff (rst)
    (text_valid && text_ready) |=> result_valid)
    else $error("accepted byte produced no result beat");

  // A stalled result beat holds its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(lead_state) && $stable(char_count)))
    else $error("result beat changed while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid straight after reset");

endmodule

bind multibyte_lead_byte_tracker mlbt_checker u_mlbt_checker (
  .clk            (clk),
  .rst            (rst),
  .text_valid     (text_valid),
  .text_ready     (text_ready),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .lead_state     (lead_state),
  .at_boundary    (at_boundary),
  .counts_as_char (counts_as_char),
  .char_count     (char_count)
);

/* tb/multibyte_lead_byte_tracker_tb.sv */
// Self-checking testbench for the multibyte lead byte tracker.
`timescale 1ns / 100ps

module multibyte_lead_byte_tracker_tb;
  import mlbt_pkg::*;

  // Codes 11 to 15 are not assigned to any encoding and must behave as single-byte.
  localparam logic [ENC_W-1:0] ENC_UNUSED_LOW = 4'd11;
  localparam logic [ENC_W-1:0] ENC_UNUSED_TOP = 4'd15;

  // Cycles with no beat on either channel and no register access before the run is
  // declared hung. The longest legitimate quiet stretch is the receiver hold-off.
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 64;
  localparam int SEG_BYTES     = 55;
  localparam int SEGS_PER_MODE = 12;

  // One result beat, field for field as the block presents it.
  typedef struct packed {
    state_t              lead;
    logic                boundary;
    logic                counted;
    logic [CHAR_W-1:0]   count;
  } tracker_result_t;

  // A directed row: encoding to select, the byte, the string start flag and, for
  // rows whose outcome is obvious, the result typed in by hand.
  typedef struct packed {
    logic [ENC_W-1:0]    enc;
    logic [BYTE_W-1:0]   value;
    logic                start;
    logic                typed;
    tracker_result_t     want;
  } directed_row_t;

  // Travels with each offered byte so the monitor knows whether a hand-typed
  // result replaces the predicted one.
  typedef struct packed {
    logic                typed;
    tracker_result_t     want;
  } beat_note_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic                text_valid   = 1'b0;
  logic                text_ready;
  logic [BYTE_W-1:0]   text_byte    = '0;
  logic                string_start = 1'b0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  logic [STATE_W-1:0]  lead_state;
  logic                at_boundary;
  logic                counts_as_char;
  logic [CHAR_W-1:0]   char_count;

  multibyte_lead_byte_tracker u_top (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .text_valid     (text_valid),
    .text_ready     (text_ready),
    .text_byte      (text_byte),
    .string_start   (string_start),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .lead_state     (lead_state),
    .at_boundary    (at_boundary),
    .counts_as_char (counts_as_char),
    .char_count     (char_count)
  );

  // 20 ns clock period.
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Predictor state: its own copy of the tracking state and the character total,
  // updated once per accepted text beat, and the selected encoding, set on each write.
  state_t                 trk_state  = '0;
  logic [COUNT_WIDTH-1:0] chars_seen = '0;
  logic [ENC_W-1:0]       enc_sel    = ENC_SINGLE;

  tracker_result_t pending_results[$];
  beat_note_t      beat_notes[$];
  logic [BYTE_W-1:0] char_bytes[$];

  int mismatches     = 0;
  int stall_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  logic hold_req     = 1'b0;

  // The directed rows walk each encoding through its lead and trail bytes, the
  // zero byte in the middle of a character, the UTF-8 stray continuation byte,
  // the GB18030 non-digit that keeps the four-byte state, encoding changes that
  // carry a part-built character over, and an unassigned encoding code.
  directed_row_t directed_rows [27] = '{
    '{ENC_SINGLE,     8'h00, 1'b1, 1'b1, '{3'd0, 1'b1, 1'b1, 16'd1}},
    '{ENC_SINGLE,     8'hff, 1'b0, 1'b1, '{3'd0, 1'b1, 1'b1, 16'd2}},
    '{ENC_UTF8,       8'hfc, 1'b1, 1'b1, '{3'd6, 1'b0, 1'b0, 16'd0}},
    '{ENC_UTF8,       8'h80, 1'b0, 1'b0, '0},
    '{ENC_UTF8,       8'h00, 1'b0, 1'b1, '{3'd0, 1'b1, 1'b1, 16'd1}},
    '{ENC_UTF8,       8'hbf, 1'b0, 1'b0, '0},
    '{ENC_UTF8,       8'hf8, 1'b0, 1'b0, '0},
    '{ENC_UTF8,       8'h41, 1'b0, 1'b0, '0},
    '{ENC_UTF8,       8'he0, 1'b0, 1'b0, '0},
    '{ENC_UTF8,       8'hc0, 1'b0, 1'b0, '0},
    '{ENC_GB18030,    8'h30, 1'b0, 1'b0, '0},
    '{ENC_GB18030,    8'h41, 1'b0, 1'b0, '0},
    '{ENC_GB18030,    8'h39, 1'b0, 1'b0, '0},
    '{ENC_SJIS2004,   8'h81, 1'b1, 1'b0, '0},
    '{ENC_SJIS2004,   8'h40, 1'b0, 1'b0, '0},
    '{ENC_SJIS,       8'ha0, 1'b1, 1'b0, '0},
    '{ENC_SJIS,       8'h9f, 1'b0, 1'b0, '0},
    '{ENC_EUC_JP,     8'h8f, 1'b1, 1'b0, '0},
    '{ENC_EUC_JP,     8'ha1, 1'b0, 1'b0, '0},
    '{ENC_EUC_JP,     8'ha1, 1'b0, 1'b0, '0},
    '{ENC_EUC_TW,     8'h8e, 1'b1, 1'b0, '0},
    '{ENC_EUC_TW,     8'ha1, 1'b0, 1'b0, '0},
    '{ENC_BIG5,       8'ha1, 1'b0, 1'b0, '0},
    '{ENC_GBK,        8'h80, 1'b1, 1'b0, '0},
    '{ENC_UHC,        8'hff, 1'b0, 1'b0, '0},
    '{ENC_EUC_CN,     8'h7f, 1'b1, 1'b0, '0},
    '{ENC_UNUSED_TOP, 8'hff, 1'b1, 1'b1, '{3'd0, 1'b1, 1'b1, 16'd1}}
  };

  // One step of the lead/trail byte rules. A zero byte always clears the state
  // first, so every rule below then sees state zero for it.
  function automatic state_t next_lead(state_t s_in, logic [BYTE_W-1:0] c,
                                       logic [ENC_W-1:0] enc);
    state_t s;
    logic   digit;
    s     = (c == 8'h00) ? state_t'(0) : s_in;
    digit = (c >= B_30) && (c <= B_39);
    case (enc)
      ENC_UTF8: begin
        if (s < 2 && c >= B_80) begin
          // A continuation byte outside a character leaves the state alone.
          if (c >= B_FC) s = 6;
          else if (c >= B_F8) s = 5;
          else if (c >= B_F0) s = 4;
          else if (c >= B_E0) s = 3;
          else if (c >= B_C0) s = 2;
        end else if (s >= 2 && c > B_7F) begin
          s = s - state_t'(1);
        end else begin
          s = 0;
        end
      end
      ENC_SJIS2004: begin
        if (s < 2 && ((c >= B_81 && c <= B_9F) || (c >= B_E0 && c <= B_FC))) s = 2;
        else if (s == 2) s = 1;
        else s = 0;
      end
      ENC_SJIS: begin
        if (s < 2 && c > B_80 && !(c > B_9F && c < B_E0)) s = 2;
        else if (s == 2) s = 1;
        else s = 0;
      end
      ENC_BIG5, ENC_EUC_CN: begin
        if (s < 2 && c > B_A0) s = 2;
        else if (s == 2) s = 1;
        else s = 0;
      end
      ENC_GBK, ENC_UHC: begin
        if (s < 2 && c > B_7F) s = 2;
        else if (s == 2) s = 1;
        else s = 0;
      end
      ENC_EUC_JP: begin
        if (s < 3 && c == B_8F) s = 3;
        else if (s != 2 && (c == B_8E || c > B_A0)) s = 2;
        else if (s == 2) s = 1;
        else s = 0;
      end
      ENC_EUC_TW: begin
        if (s < 4 && c == B_8E) s = 4;
        else if (s == 4 && c > B_A0) s = 3;
        else if ((s == 3 || s < 2) && c > B_A0) s = 2;
        else if (s == 2) s = 1;
        else s = 0;
      end
      ENC_GB18030: begin
        // In the four-byte form a non-digit third position keeps waiting.
        if (s < 2 && c > B_80) s = 2;
        else if (s == 2) s = digit ? 3 : 1;
        else if (s == 3) s = digit ? 1 : 3;
        else s = 0;
      end
      default: s = 0;
    endcase
    return s;
  endfunction

  // Advances the predictor by one accepted byte and returns the result it owes.
  function automatic tracker_result_t advance_tracker(logic [BYTE_W-1:0] c, logic st);
    tracker_result_t r;
    if (st) begin
      trk_state  = '0;
      chars_seen = '0;
    end
    trk_state  = next_lead(trk_state, c, enc_sel);
    r.lead     = trk_state;
    r.boundary = (trk_state == 0);
    r.counted  = (trk_state < 2);
    // The total sticks at its all-ones value rather than wrapping.
    if (r.counted && chars_seen != '1) chars_seen = chars_seen + 1'b1;
    r.count    = chars_seen[CHAR_W-1:0];
    return r;
  endfunction

  // Builds one character of the given encoding in char_bytes, with random content.
  function automatic void fill_char(logic [ENC_W-1:0] enc);
    int len;
    int pick;
    char_bytes.delete();
    pick = $urandom_range(0, 3);
    case (enc)
      ENC_UTF8: begin
        len = $urandom_range(1, 6);
        case (len)
          1:       char_bytes.push_back(8'($urandom_range(8'h01, 8'h7f)));
          2:       char_bytes.push_back(8'($urandom_range(8'hc0, 8'hdf)));
          3:       char_bytes.push_back(8'($urandom_range(8'he0, 8'hef)));
          4:       char_bytes.push_back(8'($urandom_range(8'hf0, 8'hf7)));
          5:       char_bytes.push_back(8'($urandom_range(8'hf8, 8'hfb)));
          default: char_bytes.push_back(8'($urandom_range(8'hfc, 8'hff)));
        endcase
        repeat (len - 1) char_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
      end
      ENC_SJIS2004, ENC_SJIS: begin
        if (pick == 0) begin
          char_bytes.push_back(8'($urandom_range(8'h01, 8'h7f)));
        end else if (pick == 1) begin
          char_bytes.push_back(8'($urandom_range(8'ha1, 8'hdf)));
        end else begin
          char_bytes.push_back(pick == 2 ? 8'($urandom_range(8'h81, 8'h9f))
                                         : 8'($urandom_range(8'he0, 8'hfc)));
          char_bytes.push_back(8'($urandom_range(8'h40, 8'hfc)));
        end
      end
      ENC_BIG5, ENC_EUC_CN: begin
        if (pick == 0) begin
          char_bytes.push_back(8'($urandom_range(8'h01, 8'h7f)));
        end else begin
          char_bytes.push_back(8'($urandom_range(8'ha1, 8'hff)));
          char_bytes.push_back(8'($urandom_range(8'h40, 8'hff)));
        end
      end
      ENC_GBK, ENC_UHC: begin
        if (pick == 0) begin
          char_bytes.push_back(8'($urandom_range(8'h01, 8'h7f)));
        end else begin
          char_bytes.push_back(8'($urandom_range(8'h80, 8'hff)));
          char_bytes.push_back(8'($urandom_range(8'h01, 8'hff)));
        end
      end
      ENC_EUC_JP: begin
        if (pick == 0) begin
          char_bytes.push_back(8'($urandom_range(8'h01, 8'h7f)));
        end else if (pick == 1) begin
          char_bytes.push_back(B_8F);
          repeat (2) char_bytes.push_back(8'($urandom_range(8'ha1, 8'hff)));
        end else if (pick == 2) begin
          char_bytes.push_back(B_8E);
          char_bytes.push_back(8'($urandom_range(8'ha1, 8'hdf)));
        end else begin
          repeat (2) char_bytes.push_back(8'($urandom_range(8'ha1, 8'hff)));
        end
      end
      ENC_EUC_TW: begin
        if (pick == 0) begin
          char_bytes.push_back(8'($urandom_range(8'h01, 8'h7f)));
        end else if (pick == 1) begin
          char_bytes.push_back(B_8E);
          char_bytes.push_back(8'($urandom_range(8'ha1, 8'hb0)));
          repeat (2) char_bytes.push_back(8'($urandom_range(8'ha1, 8'hff)));
        end else begin
          repeat (2) char_bytes.push_back(8'($urandom_range(8'ha1, 8'hff)));
        end
      end
      ENC_GB18030: begin
        if (pick == 0) begin
          char_bytes.push_back(8'($urandom_range(8'h01, 8'h7f)));
        end else if (pick == 1) begin
          char_bytes.push_back(8'($urandom_range(8'h81, 8'hfe)));
          char_bytes.push_back(8'($urandom_range(8'h40, 8'hfe)));
        end else begin
          repeat (2) begin
            char_bytes.push_back(8'($urandom_range(8'h81, 8'hfe)));
            char_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
          end
        end
      end
      default: char_bytes.push_back(8'($urandom_range(8'h01, 8'hff)));
    endcase
  endfunction

  task automatic report_error(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Offers one byte. The sender may first sit idle at random; valid is
  // only lowered when it does, so back-to-back beats keep valid high throughout.
  task automatic send_byte(logic [BYTE_W-1:0] b, logic st, logic typed,
                           tracker_result_t want);
    beat_note_t note;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    note.typed = typed;
    note.want  = want;
    beat_notes.push_back(note);
    text_valid   <= 1'b1;
    text_byte    <= b;
    string_start <= st;
    do @(posedge clk); while (!text_ready);
    @(negedge clk);
  endtask

  // Stops offering and waits until every owed result beat has come back.
  task automatic wait_for_results();
    text_valid <= 1'b0;
    while (pending_results.size() != 0 || beat_notes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write of the encoding selector, followed by a read back of it.
  task automatic write_encoding(logic [ENC_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ENCODING, 2'b00};
    pwdata  <= PDATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    enc_sel = v;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[ENC_W-1:0] != v)
      report_error($sformatf("encoding read back %0d, written %0d", prdata[ENC_W-1:0], v));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: stalls at random, or holds off for a long stretch when asked, so
  // that the block backs up and has to refuse input bytes.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor and scoreboard. The result beat is checked before the input beat of
  // the same edge is predicted, because a result always belongs to an older byte.
  always @(posedge clk) begin
    tracker_result_t got;
    tracker_result_t want;
    beat_note_t      note;
    if (!rst) begin
      if (result_valid && result_ready) begin
        got = '{lead_state, at_boundary, counts_as_char, char_count};
        if (pending_results.size() == 0) begin
          report_error($sformatf("result beat with no byte owed, lead_state %0d", got.lead));
        end else begin
          want = pending_results.pop_front();
          if (got.lead != want.lead)
            report_error($sformatf("lead_state %0d, wanted %0d", got.lead, want.lead));
          if (got.boundary != want.boundary)
            report_error($sformatf("at_boundary %0b, wanted %0b", got.boundary,
                                   want.boundary));
          if (got.counted != want.counted)
            report_error($sformatf("counts_as_char %0b, wanted %0b", got.counted,
                                   want.counted));
          if (got.count != want.count)
            report_error($sformatf("char_count %0d, wanted %0d", got.count, want.count));
        end
      end
      if (text_valid && text_ready) begin
        note = beat_notes.pop_front();
        want = advance_tracker(text_byte, string_start);
        if (note.typed) want = note.want;
        pending_results.push_back(want);
      end
    end
  end

  // Watchdog: any beat or register access counts as progress.
  always @(posedge clk) begin
    if ((text_valid && text_ready) || (result_valid && result_ready) ||
        (psel && penable && pready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus. Three idling modes in turn: sender idle 16 and receiver 54 percent
  // of the time, then the reverse, then none. Each mode runs one segment per
  // assigned encoding code and one with a random unused code; before each
  // segment the sender drains and the selector is rewritten.
  initial begin
    int send_pct_by_mode [3] = '{16, 54, 0};
    int recv_pct_by_mode [3] = '{54, 16, 0};
    int sent;
    logic [ENC_W-1:0] seg_enc;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct  = send_pct_by_mode[0];
    recv_stall_pct = recv_pct_by_mode[0];

    foreach (directed_rows[i]) begin
      if (directed_rows[i].enc != enc_sel) begin
        wait_for_results();
        write_encoding(directed_rows[i].enc);
      end
      send_byte(directed_rows[i].value, directed_rows[i].start, directed_rows[i].typed,
                directed_rows[i].want);
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct  = send_pct_by_mode[mode];
      recv_stall_pct = recv_pct_by_mode[mode];
      for (int seg = 0; seg < SEGS_PER_MODE; seg++) begin
        wait_for_results();
        seg_enc = (seg <= int'(ENC_GB18030)) ? ENC_W'(seg)
                : ENC_W'($urandom_range(ENC_UNUSED_LOW, ENC_UNUSED_TOP));
        write_encoding(seg_enc);
        // Midway through each mode the receiver goes quiet for a long stretch
        // while bytes keep coming.
        if (seg == SEGS_PER_MODE / 2) hold_req = 1'b1;
        sent = 0;
        while (sent < SEG_BYTES) begin
          if ($urandom_range(0, 9) == 0) begin
            // Noise: any byte at all, zero often enough to be seen regularly.
            char_bytes.delete();
            char_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
          end else begin
            fill_char(enc_sel);
            // Now and then a character is cut short.
            if (char_bytes.size() > 1 && $urandom_range(0, 9) == 0)
              void'(char_bytes.pop_back());
          end
          foreach (char_bytes[j]) begin
            send_byte(char_bytes[j], (sent == 0) || ($urandom_range(0, 63) == 0),
                      1'b0, '0);
            sent++;
          end
        end
      end
    end

    wait_for_results();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      report_error($sformatf("%0d result beats never arrived", pending_results.size()));
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
